@@ hdl/graph_reachability_check_unit_defines.svh @@
// assertion macros for the graph reachability check unit
`ifndef GRAPH_REACHABILITY_CHECK_UNIT_DEFINES_SVH
`define GRAPH_REACHABILITY_CHECK_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GRC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define GRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// implication that also holds across reset
`define GRC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ hdl/grc_pkg.sv @@
// shared types and constants of the graph reachability check unit
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

   localparam int OP_W          = 2;
   localparam int ZONE_W        = 5;
   localparam int CNT_W         = 6;
   localparam int DEF_MAX_ZONES = 32;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_EDGE   = 2'd0,
      OP_MARK_START = 2'd1,
      OP_VERIFY     = 2'd2,
      OP_UNUSED     = 2'd3
   } grc_op_type;

   // controller to datapath
   typedef struct packed {
      logic load_edge;
      logic load_start;
      logic start_walk;
      logic walk;
      logic load_rsp;
   } grc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic map_empty;
      logic walk_done;
   } grc_status_type;

endpackage

`default_nettype wire

@@ hdl/grc_if.sv @@
// channel interfaces: request, response and register write
`timescale 1ns / 1ps
`default_nettype none

interface grc_req_if import grc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [ZONE_W-1:0] from_zone;
   logic [ZONE_W-1:0] to_zone;

   modport source (output valid, output operation, output from_zone, output to_zone,
                   input ready);
   modport sink   (input valid, input operation, input from_zone, input to_zone,
                   output ready);
endinterface

interface grc_rsp_if import grc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             all_reached;
   logic [CNT_W-1:0] reached_count;
   logic             empty_map;

   modport source (output valid, output all_reached, output reached_count,
                   output empty_map, input ready);
   modport sink   (input valid, input all_reached, input reached_count,
                   input empty_map, output ready);
endinterface

interface grc_csr_if import grc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/graph_reachability_check_unit.sv @@
// Graph reachability check unit, top level.
// Request channel (req_bus): one beat per item. operation 0 adds the directed
// edge from_zone -> to_zone, 1 marks from_zone as a starting zone, 2 verifies,
// 3 does nothing. Zones at or above the zone count are ignored.
// Register channel (csr_bus): writes zone_count; always ready.
// Response channel (rsp_bus): one beat per verify with all_reached,
// reached_count and empty_map.
// Loads are taken back to back while idle. A verify walks the graph by
// sweeping the adjacency memory one row per cycle; the number of sweeps is
// at most the number of reached zones plus two. After the last sweep the
// controller enters its finish state and hands the result to the output
// register, which presents the response beat; an empty map (zone count zero
// or no edge) skips the walk and goes straight to the finish state.
// The request channel is not ready from the verify beat until the
// result is handed to the output register.
// Reset clears the zone count, all edges, start marks and the response valid flag.
// A stalled response is held in the output register; loads keep being taken,
// and a following verify walks but waits before overwriting the held beat.
`timescale 1ns / 1ps
`default_nettype none

module graph_reachability_check_unit
   import grc_pkg::*;
#(
   parameter int MAX_ZONES = DEF_MAX_ZONES
) (
   input  wire logic clock,
   input  wire logic reset,
   grc_req_if.sink   req_bus,
   grc_rsp_if.source rsp_bus,
   grc_csr_if.sink   csr_bus
);

   grc_cmd_type    cmd;
   grc_status_type status;

   assign csr_bus.ready = 1'b1;

   // control
   grc_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_operation (req_bus.operation),
      .req_ready     (req_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .status        (status),
      .cmd           (cmd)
   );

   // datapath
   grc_datapath #(
      .MAX_ZONES (MAX_ZONES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .from_zone     (req_bus.from_zone),
      .to_zone       (req_bus.to_zone),
      .csr_we        (csr_bus.valid),
      .csr_wdata     (csr_bus.data),
      .all_reached   (rsp_bus.all_reached),
      .reached_count (rsp_bus.reached_count),
      .empty_map     (rsp_bus.empty_map)
   );

endmodule

`default_nettype wire

@@ hdl/grc_controller.sv @@
// control state machine: beat acceptance, walk sequencing, response handoff
`timescale 1ns / 1ps
`default_nettype none

module grc_controller
   import grc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [OP_W-1:0] req_operation,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire grc_status_type  status,
   output grc_cmd_type          cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // command decode
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      accept         = req_valid && req_ready;
      cmd.load_edge  = accept && (req_operation == OP_ADD_EDGE);
      cmd.load_start = accept && (req_operation == OP_MARK_START);
      cmd.start_walk = accept && (req_operation == OP_VERIFY);
      cmd.walk       = (state_ff == ST_WALK);
      cmd.load_rsp   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_walk) begin
               state_in = status.map_empty ? ST_FINISH : ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid: set on handoff, cleared when taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/grc_datapath.sv @@
// datapath: zone count, adjacency memory, start set and the reachability walk
`timescale 1ns / 1ps
`default_nettype none

module grc_datapath
   import grc_pkg::*;
#(
   parameter int MAX_ZONES = DEF_MAX_ZONES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire grc_cmd_type       cmd,
   output grc_status_type         status,
   input  wire logic [ZONE_W-1:0] from_zone,
   input  wire logic [ZONE_W-1:0] to_zone,
   input  wire logic              csr_we,
   input  wire logic [CNT_W-1:0]  csr_wdata,
   output logic                   all_reached,
   output logic [CNT_W-1:0]       reached_count,
   output logic                   empty_map
);

   localparam int ZIW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int NW  = CNT_W + 1;

   // register and map storage
   logic [CNT_W-1:0]     zone_count_ff;
   logic [MAX_ZONES-1:0] adj_mem [MAX_ZONES];
   logic [MAX_ZONES-1:0] row_valid_ff, row_valid_in;
   logic [MAX_ZONES-1:0] start_ff, start_in;
   logic                 edge_loaded_ff, edge_loaded_in;

   // walk state
   logic [MAX_ZONES-1:0] visited_ff, visited_in;
   logic [MAX_ZONES-1:0] expanded_ff, expanded_in;
   logic [ZIW-1:0]       scan_ff, scan_in;
   logic                 pass_hit_ff, pass_hit_in;
   logic                 rd_pending_ff, rd_pending_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 empty_ff, empty_in;
   logic [MAX_ZONES-1:0] rd_row_ff;
   logic                 rd_row_ok_ff;

   // response payload
   logic                 all_reached_ff;
   logic [CNT_W-1:0]     reached_count_ff;
   logic                 empty_map_ff;

   logic [NW-1:0]        live_n;
   logic [MAX_ZONES-1:0] live_mask;
   logic [ZIW-1:0]       src_idx, dst_idx;
   logic [MAX_ZONES-1:0] dst_onehot;
   logic                 src_ok, dst_ok, edge_ok;
   logic                 map_empty;
   logic [MAX_ZONES-1:0] pending, row_eff;
   logic                 issue, scan_last;

   // effective zone count and live mask
   always_comb begin
      if ({1'b0, zone_count_ff} > NW'(MAX_ZONES)) begin
         live_n = NW'(MAX_ZONES);
      end else begin
         live_n = {1'b0, zone_count_ff};
      end
      for (int z = 0; z < MAX_ZONES; z++) begin
         live_mask[z] = (NW'(z) < live_n);
      end
   end

   // load decode
   always_comb begin
      src_ok     = ({{(NW-ZONE_W){1'b0}}, from_zone} < live_n);
      dst_ok     = ({{(NW-ZONE_W){1'b0}}, to_zone} < live_n);
      edge_ok    = cmd.load_edge && src_ok && dst_ok;
      src_idx    = ZIW'(from_zone);
      dst_idx    = ZIW'(to_zone);
      dst_onehot = '0;
      dst_onehot[dst_idx] = 1'b1;
      map_empty  = (live_n == '0) || !edge_loaded_ff;
   end

   // walk scan
   always_comb begin
      pending   = visited_ff & ~expanded_ff;
      issue     = cmd.walk && pending[scan_ff];
      scan_last = (scan_ff == ZIW'(MAX_ZONES - 1));
      row_eff   = rd_row_ok_ff ? rd_row_ff : '0;
   end

   // next values
   always_comb begin
      row_valid_in   = row_valid_ff;
      start_in       = start_ff;
      edge_loaded_in = edge_loaded_ff;
      visited_in     = visited_ff;
      expanded_in    = expanded_ff;
      scan_in        = scan_ff;
      pass_hit_in    = pass_hit_ff;
      count_in       = count_ff;
      empty_in       = empty_ff;
      rd_pending_in  = issue;

      if (edge_ok) begin
         row_valid_in[src_idx] = 1'b1;
         edge_loaded_in        = 1'b1;
      end
      if (cmd.load_start && src_ok) begin
         start_in[src_idx] = 1'b1;
      end

      if (cmd.start_walk) begin
         empty_in    = map_empty;
         visited_in  = map_empty ? '0 : (start_ff & live_mask);
         expanded_in = '0;
         scan_in     = '0;
         pass_hit_in = 1'b0;
         count_in    = '0;
      end else begin
         // merge the row read last cycle
         if (rd_pending_ff) begin
            visited_in = visited_ff | (row_eff & live_mask);
         end
         if (issue) begin
            expanded_in[scan_ff] = 1'b1;
            count_in             = count_ff + 1'b1;
         end
         // a row issued on the last slot merges during the next sweep,
         // so that sweep must not be taken as the final one
         if (cmd.walk) begin
            scan_in     = scan_last ? '0 : scan_ff + 1'b1;
            pass_hit_in = scan_last ? issue : (pass_hit_ff || issue);
         end
      end
   end

   always_comb begin
      status.map_empty = map_empty;
      status.walk_done = cmd.walk && scan_last && !pass_hit_ff && !issue;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_count_ff  <= '0;
         row_valid_ff   <= '0;
         start_ff       <= '0;
         edge_loaded_ff <= 1'b0;
         pass_hit_ff    <= 1'b0;
         rd_pending_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            zone_count_ff <= csr_wdata;
         end
         row_valid_ff   <= row_valid_in;
         start_ff       <= start_in;
         edge_loaded_ff <= edge_loaded_in;
         pass_hit_ff    <= pass_hit_in;
         rd_pending_ff  <= rd_pending_in;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      visited_ff  <= visited_in;
      expanded_ff <= expanded_in;
      scan_ff     <= scan_in;
      count_ff    <= count_in;
      empty_ff    <= empty_in;
   end

   // adjacency memory: bit write on load, registered row read on scan
   always_ff @(posedge clock) begin
      if (edge_ok) begin
         if (row_valid_ff[src_idx]) begin
            adj_mem[src_idx][dst_idx] <= 1'b1;
         end else begin
            adj_mem[src_idx] <= dst_onehot;
         end
      end
      rd_row_ff    <= adj_mem[scan_ff];
      rd_row_ok_ff <= row_valid_ff[scan_ff];
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         all_reached_ff   <= !empty_ff && ({1'b0, count_ff} == live_n);
         reached_count_ff <= count_ff;
         empty_map_ff     <= empty_ff;
      end
   end

   assign all_reached   = all_reached_ff;
   assign reached_count = reached_count_ff;
   assign empty_map     = empty_map_ff;

endmodule

`default_nettype wire

@@ hdl/grc_checker.sv @@
// port-level checker of the graph reachability check unit and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "graph_reachability_check_unit_defines.svh"

module grc_checker
   import grc_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic [OP_W-1:0]  req_operation,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             all_reached,
   input wire logic [CNT_W-1:0] reached_count,
   input wire logic             empty_map
);

   // no response beat right after reset
   `GRC_ASSERT_ALWAYS(a_rsp_clear_after_reset, clock, $past(reset), !rsp_valid, "response valid after reset")

   // a verify beat closes the request side in the following cycle
   `GRC_ASSERT_NEXT(a_verify_blocks, clock, reset, req_valid && req_ready && (req_operation == OP_VERIFY), !req_ready, "request ready right after verify")

   // an empty map never passes
   `GRC_ASSERT_NOW(a_empty_fails, clock, reset, rsp_valid && empty_map, !all_reached && (reached_count == '0), "empty map reported as reached")

   // a stalled response beat holds
   `GRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(all_reached) && $stable(reached_count) && $stable(empty_map), "stalled response changed")

endmodule

bind graph_reachability_check_unit grc_checker u_grc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_operation (req_bus.operation),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .all_reached   (rsp_bus.all_reached),
   .reached_count (rsp_bus.reached_count),
   .empty_map     (rsp_bus.empty_map)
);

`default_nettype wire
